FILE: sv/matrix_profile_diagonal_engine_defines.svh
// Assertion macros for the matrix-profile diagonal engine checker.
// No dependencies; included by the checker file.
`ifndef MATRIX_PROFILE_DIAGONAL_ENGINE_DEFINES_SVH
`define MATRIX_PROFILE_DIAGONAL_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MPDE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPDE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/mpde_pkg.sv
// Shared constants, types and helpers for the matrix-profile diagonal engine.
// No dependencies.
`default_nettype none

package mpde_pkg;

   localparam int MAX_SERIES = 1024;
   localparam int MAX_WINDOW = 256;
   localparam int MIN_WINDOW = 4;
   localparam int MIN_LENGTH = 8;

   localparam int ADDR_W   = $clog2(MAX_SERIES);
   localparam int WIN_W    = $clog2(MAX_WINDOW) + 1;
   localparam int LEN_W    = $clog2(MAX_SERIES) + 1;
   localparam int SAMPLE_W = 16;
   localparam int TERM_W   = 24;
   localparam int PREFIX_W = 48;
   localparam int DIFF_W   = PREFIX_W + 1;
   localparam int CORR_W   = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LEN_W;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd1;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);
   localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(MAX_SERIES);

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_DIAG  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   // one entry of the series memory
   typedef struct packed {
      logic signed [PREFIX_W-1:0] prefix;
      logic signed [TERM_W-1:0]   mean;
      logic signed [TERM_W-1:0]   sigma;
      logic signed [SAMPLE_W-1:0] series;
   } point_type;

   // one entry of the profile memory
   typedef struct packed {
      logic signed [CORR_W-1:0] corr;
      logic [ADDR_W-1:0]        idx;
   } best_type;

   // correlation for one i/j pair, offered to the profile
   typedef struct packed {
      logic                     valid;
      logic [ADDR_W-1:0]        j;
      logic [ADDR_W-1:0]        i;
      logic signed [CORR_W-1:0] corr;
   } prof_upd_type;

   typedef struct packed {
      logic              clr_en;
      logic [ADDR_W-1:0] clr_addr;
      logic [ADDR_W-1:0] rd_addr;
   } prof_ctl_type;

   localparam logic signed [47:0] CORR_HI = 48'sd549755813887;
   localparam logic signed [47:0] CORR_LO = -48'sd549755813888;

   function automatic logic signed [CORR_W-1:0] sat_corr(input logic signed [47:0] x);
      logic signed [CORR_W-1:0] r;
      if (x > CORR_HI) begin
         r = CORR_HI[CORR_W-1:0];
      end else if (x < CORR_LO) begin
         r = CORR_LO[CORR_W-1:0];
      end else begin
         r = x[CORR_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/mpde_corr.sv
// Correlation pipeline: window dot product, sigma and mean products, rounding
// and saturation, four register stages. Depends on mpde_pkg.
`default_nettype none

module mpde_corr
   import mpde_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic signed [DIFF_W-1:0]   in_diff,
   input  wire logic signed [TERM_W-1:0]   in_sig_j,
   input  wire logic signed [TERM_W-1:0]   in_sig_i,
   input  wire logic signed [TERM_W-1:0]   in_mean_j,
   input  wire logic signed [TERM_W-1:0]   in_mean_i,
   input  wire logic [ADDR_W-1:0]          in_j,
   input  wire logic [ADDR_W-1:0]          in_i,
   output prof_upd_type                    upd,
   output logic                            busy
);

   logic                 v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0]    j1_ff, i1_ff, j2_ff, i2_ff, j3_ff, i3_ff;
   logic signed [25:0]   dot1_ff, dot2_ff;
   logic signed [47:0]   spp1_ff, mpp1_ff;
   logic signed [31:0]   sp2_ff;
   logic signed [32:0]   mp2_ff, mp3_ff;
   logic signed [57:0]   tp3_ff;
   logic                     out_valid_ff;
   logic [ADDR_W-1:0]        out_j_ff, out_i_ff;
   logic signed [CORR_W-1:0] out_corr_ff;

   logic signed [49:0]   dsum;
   logic signed [48:0]   spsum, mpsum;
   logic signed [58:0]   tsum;
   logic signed [43:0]   term;
   logic signed [47:0]   corr_wide;

   // round half up: add half, arithmetic shift
   assign dsum      = 50'(in_diff) + 50'sd16384;
   assign spsum     = 49'(spp1_ff) + 49'sd32768;
   assign mpsum     = 49'(mpp1_ff) + 49'sd32768;
   assign tsum      = 59'(tp3_ff) + 59'sd16384;
   assign term      = $signed(tsum[58:15]);
   assign corr_wide = 48'(term) - 48'(mp3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      // window sum of products stays within 2^38, so the dot fits 26 bits
      dot1_ff <= $signed(dsum[40:15]);
      spp1_ff <= in_sig_j * in_sig_i;
      mpp1_ff <= in_mean_j * in_mean_i;
      j1_ff   <= in_j;
      i1_ff   <= in_i;

      dot2_ff <= dot1_ff;
      sp2_ff  <= $signed(spsum[47:16]);
      mp2_ff  <= $signed(mpsum[48:16]);
      j2_ff   <= j1_ff;
      i2_ff   <= i1_ff;

      tp3_ff  <= dot2_ff * sp2_ff;
      mp3_ff  <= mp2_ff;
      j3_ff   <= j2_ff;
      i3_ff   <= i2_ff;

      out_corr_ff <= sat_corr(corr_wide);
      out_j_ff    <= j3_ff;
      out_i_ff    <= i3_ff;
   end

   assign upd  = '{valid: out_valid_ff, j: out_j_ff, i: out_i_ff, corr: out_corr_ff};
   assign busy = v1_ff | v2_ff | v3_ff | out_valid_ff;

endmodule

`default_nettype wire

FILE: sv/mpde_prof.sv
// Profile memory: best correlation and partner index per entry, with the
// read-compare-write update for both ends of a pair. Depends on mpde_pkg.
`default_nettype none

module mpde_prof
   import mpde_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  prof_ctl_type ctl,
   input  prof_upd_type upd,
   output best_type    rd_entry,
   output logic        busy
);

   best_type                 best_mem_ff [MAX_SERIES];
   best_type                 rda_ff, rdb_ff;

   logic                     bv_ff, wi_ff;
   logic [ADDR_W-1:0]        bj_ff, bi_ff, wi_addr_ff, wi_idx_ff;
   logic signed [CORR_W-1:0] bcorr_ff, wcorr_ff;

   logic [ADDR_W-1:0]        addr_a;
   logic                     gt_j, gt_i;
   logic                     we;
   logic [ADDR_W-1:0]        waddr;
   best_type                 wdata;

   assign addr_a = upd.valid ? upd.j : ctl.rd_addr;
   assign gt_j   = bcorr_ff > rda_ff.corr;
   assign gt_i   = bcorr_ff > rdb_ff.corr;

   // j end is written in the cycle after the read, i end in the cycle after that;
   // pairs never arrive back to back, so writes never collide
   always_comb begin
      we    = 1'b0;
      waddr = ctl.clr_addr;
      wdata = '0;
      if (ctl.clr_en) begin
         we = 1'b1;
      end else if (bv_ff && gt_j) begin
         we         = 1'b1;
         waddr      = bj_ff;
         wdata.corr = bcorr_ff;
         wdata.idx  = bi_ff;
      end else if (wi_ff) begin
         we         = 1'b1;
         waddr      = wi_addr_ff;
         wdata.corr = wcorr_ff;
         wdata.idx  = wi_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         best_mem_ff[waddr] <= wdata;
      end
      rda_ff <= best_mem_ff[addr_a];
      rdb_ff <= best_mem_ff[upd.i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
         wi_ff <= 1'b0;
      end else begin
         bv_ff <= upd.valid;
         wi_ff <= bv_ff && gt_i;
      end
   end

   always_ff @(posedge clock) begin
      bj_ff      <= upd.j;
      bi_ff      <= upd.i;
      bcorr_ff   <= upd.corr;
      wi_addr_ff <= bi_ff;
      wi_idx_ff  <= bj_ff;
      wcorr_ff   <= bcorr_ff;
   end

   assign rd_entry = rda_ff;
   assign busy     = bv_ff | wi_ff;

endmodule

`default_nettype wire

FILE: sv/matrix_profile_diagonal_engine.sv
// Top level of the matrix-profile diagonal engine: sequencer, series memory,
// prefix pass. Depends on mpde_pkg, mpde_corr, mpde_prof.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | mode position sample sigma_inv
//           |           |                      | mean_term diagonal
//   rsp_    | out       | rsp_valid/rsp_stall  | status distance neighbour
//   csr_    | in        | csr_write            | csr_index csr_data
//
// A diagonal takes one prefix term per cycle, then its pairs, which are never issued
// back to back, bound by the single profile write port. After reset a sweep zeroes
// the profile; req_stall stays high. Requests are taken one at a time; the result
// register lets the next one in while a result waits on rsp_stall.
`default_nettype none

module matrix_profile_diagonal_engine
   import mpde_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_mode,
   input  wire logic [ADDR_W-1:0]          req_position,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic signed [TERM_W-1:0]   req_sigma_inv,
   input  wire logic signed [TERM_W-1:0]   req_mean_term,
   input  wire logic [ADDR_W-1:0]          req_diagonal,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_status,
   output logic signed [CORR_W-1:0]        rsp_distance,
   output logic [ADDR_W-1:0]               rsp_neighbour,
   input  wire logic                       csr_write,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_P1, ST_P1_DRAIN, ST_P2, ST_P2_DRAIN, ST_PUSH
   } state_type;

   state_type                state_ff;
   logic [WIN_W-1:0]         window_ff;
   logic [LEN_W-1:0]         length_ff;
   logic [ADDR_W-1:0]        clr_addr_ff, d_ff, t_ff, j_ff;
   logic                     clr_push_ff, phase_ff;
   logic                     res_status_ff;
   logic signed [CORR_W-1:0] res_dist_ff;
   logic [ADDR_W-1:0]        res_nb_ff;
   logic                     rsp_valid_ff, rsp_status_ff;
   logic signed [CORR_W-1:0] rsp_distance_ff;
   logic [ADDR_W-1:0]        rsp_neighbour_ff;

   // effective configuration
   logic [WIN_W-1:0]  m_eff, m_quarter;
   logic [LEN_W-1:0]  l_eff, prof_len, l_m1, p_m1, hi_sum;
   logic [ADDR_W-1:0] l_last, p_last, hi_addr;

   always_comb begin
      m_eff = window_ff;
      if (window_ff < WIN_W'(MIN_WINDOW)) begin
         m_eff = WIN_W'(MIN_WINDOW);
      end else if (window_ff > WIN_W'(MAX_WINDOW)) begin
         m_eff = WIN_W'(MAX_WINDOW);
      end
      l_eff = length_ff;
      if (length_ff < LEN_W'(MIN_LENGTH)) begin
         l_eff = LEN_W'(MIN_LENGTH);
      end else if (length_ff > LEN_W'(MAX_SERIES)) begin
         l_eff = LEN_W'(MAX_SERIES);
      end
      prof_len = (LEN_W'(m_eff) > l_eff) ? '0 : l_eff - LEN_W'(m_eff) + LEN_W'(1);
   end

   assign m_quarter = m_eff >> 2;
   assign l_m1      = l_eff - LEN_W'(1);
   assign p_m1      = prof_len - LEN_W'(1);
   assign l_last    = l_m1[ADDR_W-1:0];
   assign p_last    = p_m1[ADDR_W-1:0];
   assign hi_sum    = LEN_W'(j_ff) + LEN_W'(m_eff) - LEN_W'(1);
   assign hi_addr   = hi_sum[ADDR_W-1:0];

   // request decode
   logic     accept, diag_bad, read_bad, p1_start, load_wr;
   mode_type req_mode_t;

   assign req_mode_t = mode_type'(req_mode);
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign diag_bad   = (LEN_W'(req_diagonal) <= LEN_W'(m_quarter)) ||
                       (LEN_W'(req_diagonal) >= prof_len);
   assign read_bad   = LEN_W'(req_position) >= prof_len;
   assign p1_start   = accept && (req_mode_t == MODE_DIAG) && !diag_bad;
   assign load_wr    = accept && (req_mode_t == MODE_LOAD);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         length_ff <= LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW: window_ff <= csr_data[WIN_W-1:0];
            CSR_LENGTH: length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // series memory: sample, sigma, mean, prefix sum per point
   point_type         point_mem_ff [MAX_SERIES];
   point_type         pt_rda_ff, pt_rdb_ff;
   logic [ADDR_W-1:0] pt_addr_a, pt_addr_b, pt_waddr;
   logic              pt_we;
   point_type         pt_wmask, pt_wdata;

   logic              p1_issue, p2_issue;
   logic              p1v1_ff, p1v2_ff, pv1_ff, pv2_ff, first1_ff;
   logic [ADDR_W-1:0] p1t1_ff, p1t2_ff, j1_ff, i1_ff, j2_ff, i2_ff;
   logic signed [2*SAMPLE_W-1:0] prod_ff;
   logic signed [PREFIX_W-1:0]   run_ff, run_in, lo_sel;
   logic signed [DIFF_W-1:0]     diff_ff;

   assign p1_issue = (state_ff == ST_P1);
   assign p2_issue = (state_ff == ST_P2) && !phase_ff;
   assign run_in   = run_ff + PREFIX_W'(prod_ff);
   assign lo_sel   = first1_ff ? '0 : pt_rdb_ff.prefix;

   // series pairs in P1; in P2 prefix, then sigma/mean pairs, on alternate cycles
   always_comb begin
      if (pv1_ff) begin
         pt_addr_a = j1_ff;
         pt_addr_b = i1_ff;
      end else if (p2_issue) begin
         pt_addr_a = hi_addr;
         pt_addr_b = j_ff - ADDR_W'(1);
      end else begin
         pt_addr_a = t_ff;
         pt_addr_b = t_ff - d_ff;
      end
   end

   always_comb begin
      pt_we    = 1'b0;
      pt_waddr = req_position;
      pt_wmask = '0;
      pt_wdata = '0;
      if (load_wr) begin
         pt_we          = 1'b1;
         pt_wmask.series = '1;
         pt_wmask.sigma  = '1;
         pt_wmask.mean   = '1;
         pt_wdata.series = req_sample;
         pt_wdata.sigma  = req_sigma_inv;
         pt_wdata.mean   = req_mean_term;
      end else if (p1v2_ff) begin
         pt_we           = 1'b1;
         pt_waddr        = p1t2_ff;
         pt_wmask.prefix = '1;
         pt_wdata.prefix = run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         for (int b = 0; b < $bits(point_type); b++) begin
            if (pt_wmask[b]) begin
               point_mem_ff[pt_waddr][b] <= pt_wdata[b];
            end
         end
      end
      pt_rda_ff <= point_mem_ff[pt_addr_a];
      pt_rdb_ff <= point_mem_ff[pt_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v1_ff <= 1'b0;
         p1v2_ff <= 1'b0;
         pv1_ff  <= 1'b0;
         pv2_ff  <= 1'b0;
      end else begin
         p1v1_ff <= p1_issue;
         p1v2_ff <= p1v1_ff;
         pv1_ff  <= p2_issue;
         pv2_ff  <= pv1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1t1_ff <= t_ff;
      p1t2_ff <= p1t1_ff;
      prod_ff <= pt_rda_ff.series * pt_rdb_ff.series;
      if (p1_start) begin
         run_ff <= '0;
      end else if (p1v2_ff) begin
         run_ff <= run_in;
      end
      j1_ff     <= j_ff;
      i1_ff     <= j_ff - d_ff;
      first1_ff <= (j_ff == d_ff);
      diff_ff   <= DIFF_W'(pt_rda_ff.prefix) - DIFF_W'(lo_sel);
      j2_ff     <= j1_ff;
      i2_ff     <= i1_ff;
   end

   // correlation and profile
   prof_upd_type upd;
   prof_ctl_type prof_ctl;
   best_type     prof_rd;
   logic         corr_busy, prof_busy;

   mpde_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv2_ff),
      .in_diff   (diff_ff),
      .in_sig_j  (pt_rda_ff.sigma),
      .in_sig_i  (pt_rdb_ff.sigma),
      .in_mean_j (pt_rda_ff.mean),
      .in_mean_i (pt_rdb_ff.mean),
      .in_j      (j2_ff),
      .in_i      (i2_ff),
      .upd       (upd),
      .busy      (corr_busy)
   );

   assign prof_ctl.clr_en   = (state_ff == ST_CLEAR);
   assign prof_ctl.clr_addr = clr_addr_ff;
   assign prof_ctl.rd_addr  = req_position;

   mpde_prof u_prof (
      .clock    (clock),
      .reset    (reset),
      .ctl      (prof_ctl),
      .upd      (upd),
      .rd_entry (prof_rd),
      .busy     (prof_busy)
   );

   // read-mode distance: 2m - 2*corr, saturated
   logic signed [41:0] twice_m, twice_c, dist_wide;
   assign twice_m   = $signed(42'(m_eff) << 17);
   assign twice_c   = 42'(prof_rd.corr) <<< 1;
   assign dist_wide = twice_m - twice_c;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_push_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // ST_PUSH handles the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_PUSH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == '1) begin
                  state_ff <= clr_push_ff ? ST_PUSH : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  res_status_ff <= STATUS_OK;
                  res_dist_ff   <= '0;
                  res_nb_ff     <= '0;
                  case (req_mode_t)
                     MODE_LOAD: state_ff <= ST_PUSH;
                     MODE_DIAG: begin
                        if (diag_bad) begin
                           res_status_ff <= STATUS_RANGE;
                           state_ff      <= ST_PUSH;
                        end else begin
                           d_ff     <= req_diagonal;
                           t_ff     <= req_diagonal;
                           state_ff <= ST_P1;
                        end
                     end
                     MODE_READ: begin
                        if (read_bad) begin
                           res_status_ff <= STATUS_RANGE;
                           state_ff      <= ST_PUSH;
                        end else begin
                           state_ff <= ST_READ;
                        end
                     end
                     MODE_CLEAR: begin
                        clr_addr_ff <= '0;
                        clr_push_ff <= 1'b1;
                        state_ff    <= ST_CLEAR;
                     end
                     default: state_ff <= ST_PUSH;
                  endcase
               end
            end
            ST_READ: begin
               res_dist_ff <= sat_corr(48'(dist_wide));
               res_nb_ff   <= prof_rd.idx;
               state_ff    <= ST_PUSH;
            end
            ST_P1: begin
               t_ff <= t_ff + ADDR_W'(1);
               if (t_ff == l_last) begin
                  state_ff <= ST_P1_DRAIN;
               end
            end
            ST_P1_DRAIN: begin
               // last prefix write must land before the pair pass reads it
               if (!p1v1_ff && !p1v2_ff) begin
                  j_ff     <= d_ff;
                  phase_ff <= 1'b0;
                  state_ff <= ST_P2;
               end
            end
            ST_P2: begin
               phase_ff <= !phase_ff;
               if (!phase_ff) begin
                  j_ff <= j_ff + ADDR_W'(1);
                  if (j_ff == p_last) begin
                     state_ff <= ST_P2_DRAIN;
                  end
               end
            end
            ST_P2_DRAIN: begin
               if (!pv1_ff && !pv2_ff && !corr_busy && !prof_busy) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= res_status_ff;
                  rsp_distance_ff  <= res_dist_ff;
                  rsp_neighbour_ff <= res_nb_ff;
                  clr_push_ff      <= 1'b0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_neighbour = rsp_neighbour_ff;

endmodule

`default_nettype wire

FILE: sv/mpde_chk.sv
// Port-level checker for the matrix-profile diagonal engine, bound to the top.
// Depends on mpde_pkg and matrix_profile_diagonal_engine_defines.svh.
`default_nettype none
`include "matrix_profile_diagonal_engine_defines.svh"

module mpde_chk
   import mpde_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic                       rsp_status,
   input wire logic signed [CORR_W-1:0]   rsp_distance,
   input wire logic [ADDR_W-1:0]          rsp_neighbour
);

   `MPDE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result beat dropped")

   // one request in flight: the beat after an accept is always stalled
   `MPDE_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "second request taken")

   // an error result carries no distance or neighbour
   `MPDE_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status == STATUS_RANGE, !(|{rsp_distance, rsp_neighbour}), "error beat has data")

   // the clearing sweep holds off requests right after reset
   `MPDE_ASSERT_NOW(a_sweep, $fell(reset), req_stall, "request taken before sweep")

endmodule

bind matrix_profile_diagonal_engine mpde_chk u_chk (.*);

`default_nettype wire
